/* rtl/core/ellr_pkg.sv */
// shared constants and types for the ellipse outline rasterizer
// holds register indexes, op codes, mirror codes and the pixel request bundle
// no dependencies
package ellr_pkg;

    localparam int CLIP_BITS      = 12;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_HEIGHT = 1'd1;

    localparam logic [CLIP_BITS-1:0] CLIP_WIDTH_RESET  = 12'd120;
    localparam logic [CLIP_BITS-1:0] CLIP_HEIGHT_RESET = 12'd40;

    localparam logic OP_START = 1'b0;

    // mirror order of the four pixels of one point
    localparam logic [1:0] QUAD_PP = 2'd0;
    localparam logic [1:0] QUAD_PM = 2'd1;
    localparam logic [1:0] QUAD_MP = 2'd2;
    localparam logic [1:0] QUAD_MM = 2'd3;

    typedef struct packed {
        logic       load;
        logic [1:0] quad;
        logic       final_pt;
    } pix_req_t;

endpackage

/* rtl/core/ellipse_outline_rasterizer.sv */
// midpoint ellipse outline rasterizer: a start item squares the radii and sets up
// the decision; a step item emits 4 pixels (one per cycle while out_ready is high)
// and updates point and decision, plus region change terms on entering region 2;
// all on one multiplier; one item in flight; in_ready is high only while idle
// asynchronous active-low reset clears the sequencer, the drawing flag and the
// clip registers (120 by 40); no pixel is pending after reset
module ellipse_outline_rasterizer #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write_en,
    input  logic [ellr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [ellr_pkg::CLIP_BITS-1:0]          cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    op,
    input  logic signed [COORD_BITS-1:0]            center_x,
    input  logic signed [COORD_BITS-1:0]            center_y,
    input  logic signed [RADIUS_BITS:0]             radius_x,
    input  logic signed [RADIUS_BITS:0]             radius_y,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [COORD_BITS:0]              pixel_x,
    output logic signed [COORD_BITS:0]              pixel_y,
    output logic                                    on_screen,
    output logic                                    last_of_point,
    output logic                                    last_of_shape
);

    localparam int R   = RADIUS_BITS;
    localparam int PW  = R + 2;
    localparam int SQW = 2 * R;
    localparam int SW  = 3 * R + 3;
    localparam int DW  = 4 * R + 8;
    localparam int AW  = 2 * R + 5;
    localparam int PRW = 2 * AW;

    typedef enum logic [14:0] {
        ST_IDLE    = 15'h0001,
        ST_SQ_RX   = 15'h0002,
        ST_SQ_RY   = 15'h0004,
        ST_SLOPE   = 15'h0008,
        ST_INIT_D  = 15'h0010,
        ST_EMIT    = 15'h0020,
        ST_UPD_POS = 15'h0040,
        ST_UPD_SUM = 15'h0080,
        ST_UPD_DEC = 15'h0100,
        ST_SW_DX   = 15'h0200,
        ST_SW_DY   = 15'h0400,
        ST_SW_RYDX = 15'h0800,
        ST_SW_RXDY = 15'h1000,
        ST_SW_ADD  = 15'h2000,
        ST_SW_SUB  = 15'h4000
    } state_t;

    state_t state_reg, state_next;
    logic   drawing_reg, drawing_next;
    logic   region_reg, region_next;
    logic   br_reg, br_next;
    logic [1:0] quad_reg, quad_next;
    logic [ellr_pkg::CLIP_BITS-1:0] clip_w_reg, clip_h_reg;

    logic signed [COORD_BITS-1:0] ccol_reg, ccol_next, crow_reg, crow_next;
    logic signed [PW-1:0]  px_reg, px_next, py_reg, py_next;
    logic [SQW-1:0]        rx2_reg, rx2_next, ry2_reg, ry2_next;
    logic signed [SW-1:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic signed [DW-1:0]  d_reg, d_next, t_reg, t_next;

    logic signed [AW-1:0]  mult_a, mult_b;
    logic signed [PRW-1:0] prod;
    logic signed [DW-1:0]  prod_d, prod4, t4, rx2_d, ry2_d, sx_d, sy_d;
    logic signed [DW-1:0]  sum_base, sum_sx, sum_sy;
    logic signed [SW-1:0]  two_rx2, two_ry2;
    logic signed [PW-1:0]  one_p;
    logic signed [PW-1:0]  py_m1;
    logic                  rx_pos, ry_pos;

    ellr_pkg::pix_req_t pix_req;
    logic               pix_free;

    assign in_ready = (state_reg == ST_IDLE);

    assign prod_d  = prod[DW-1:0];
    assign prod4   = {prod[DW-3:0], 2'b00};
    assign t4      = {t_reg[DW-3:0], 2'b00};
    assign rx2_d   = {{(DW-SQW){1'b0}}, rx2_reg};
    assign ry2_d   = {{(DW-SQW){1'b0}}, ry2_reg};
    assign sx_d    = {{(DW-SW){sx_reg[SW-1]}}, sx_reg};
    assign sy_d    = {{(DW-SW){sy_reg[SW-1]}}, sy_reg};
    assign two_rx2 = {{(SW-SQW-1){1'b0}}, rx2_reg, 1'b0};
    assign two_ry2 = {{(SW-SQW-1){1'b0}}, ry2_reg, 1'b0};
    assign one_p   = {{(PW-1){1'b0}}, 1'b1};
    // row can be zero at the region change, so y-1 may be negative
    assign py_m1   = py_reg - one_p;
    assign rx_pos  = !radius_x[R] && (radius_x != '0);
    assign ry_pos  = !radius_y[R] && (radius_y != '0);

    // decision increment: region 1 always adds sx and subtracts sy only when the row moves,
    // region 2 always subtracts sy and adds sx only when the column moves
    assign sum_base = region_reg ? rx2_d : ry2_d;
    assign sum_sx   = (!region_reg || !br_reg) ? sx_d : '0;
    assign sum_sy   = (region_reg || !br_reg) ? sy_d : '0;

    // operand selection for the shared multiplier
    always_comb
    begin
        mult_a = '0;
        mult_b = '0;
        unique case (state_reg)
            ST_SQ_RX:
            begin
                mult_a = {{(AW-PW){px_reg[PW-1]}}, px_reg};
                mult_b = {{(AW-PW){px_reg[PW-1]}}, px_reg};
            end
            ST_SQ_RY:
            begin
                mult_a = {{(AW-PW){py_reg[PW-1]}}, py_reg};
                mult_b = {{(AW-PW){py_reg[PW-1]}}, py_reg};
            end
            ST_SLOPE:
            begin
                mult_a = {{(AW-SQW){1'b0}}, rx2_reg};
                mult_b = {{(AW-PW){py_reg[PW-1]}}, py_reg};
            end
            ST_SW_DX:
            begin
                // 2x+1
                mult_a = {{(AW-PW-1){px_reg[PW-1]}}, px_reg, 1'b1};
                mult_b = {{(AW-PW-1){px_reg[PW-1]}}, px_reg, 1'b1};
            end
            ST_SW_DY:
            begin
                mult_a = {{(AW-PW){py_m1[PW-1]}}, py_m1};
                mult_b = {{(AW-PW){py_m1[PW-1]}}, py_m1};
            end
            ST_SW_RYDX:
            begin
                mult_a = {{(AW-SQW){1'b0}}, ry2_reg};
                mult_b = t_reg[AW-1:0];
            end
            ST_SW_RXDY:
            begin
                mult_a = {{(AW-SQW){1'b0}}, rx2_reg};
                mult_b = t_reg[AW-1:0];
            end
            ST_SW_ADD:
            begin
                mult_a = {{(AW-SQW){1'b0}}, rx2_reg};
                mult_b = {{(AW-SQW){1'b0}}, ry2_reg};
            end
            default:
            begin
                mult_a = '0;
                mult_b = '0;
            end
        endcase
    end

    ellr_mult #(
        .OP_BITS (AW)
    ) u_mult (
        .clk  (clk),
        .a    (mult_a),
        .b    (mult_b),
        .prod (prod)
    );

    assign pix_req.load     = (state_reg == ST_EMIT) && pix_free;
    assign pix_req.quad     = quad_reg;
    assign pix_req.final_pt = region_reg && (py_reg == '0);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        drawing_next = drawing_reg;
        region_next  = region_reg;
        br_next      = br_reg;
        quad_next    = quad_reg;
        ccol_next    = ccol_reg;
        crow_next    = crow_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        rx2_next     = rx2_reg;
        ry2_next     = ry2_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        d_next       = d_reg;
        t_next       = t_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == ellr_pkg::OP_START)
                    begin
                        drawing_next = 1'b0;
                        if (rx_pos && ry_pos)
                        begin
                            ccol_next   = center_x;
                            crow_next   = center_y;
                            // radius x parks in the column until squared
                            px_next     = {radius_x[R], radius_x};
                            py_next     = {radius_y[R], radius_y};
                            region_next = 1'b0;
                            state_next  = ST_SQ_RX;
                        end
                    end
                    else if (drawing_reg)
                    begin
                        quad_next  = ellr_pkg::QUAD_PP;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SQ_RX:
            begin
                state_next = ST_SQ_RY;
            end
            ST_SQ_RY:
            begin
                rx2_next   = prod[SQW-1:0];
                state_next = ST_SLOPE;
            end
            ST_SLOPE:
            begin
                ry2_next   = prod[SQW-1:0];
                px_next    = '0;
                sx_next    = '0;
                state_next = ST_INIT_D;
            end
            ST_INIT_D:
            begin
                sy_next      = {prod[SW-2:0], 1'b0};
                d_next       = {ry2_d[DW-3:0], 2'b00} + rx2_d - prod4;
                drawing_next = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (pix_free)
                begin
                    quad_next = quad_reg + 2'd1;
                    if (quad_reg == ellr_pkg::QUAD_MM)
                    begin
                        state_next = ST_UPD_POS;
                    end
                end
            end
            ST_UPD_POS:
            begin
                if (!region_reg)
                begin
                    px_next = px_reg + one_p;
                    sx_next = sx_reg + two_ry2;
                    br_next = d_reg[DW-1];
                    if (!d_reg[DW-1])
                    begin
                        py_next = py_reg - one_p;
                        sy_next = sy_reg - two_rx2;
                    end
                end
                else
                begin
                    py_next = py_reg - one_p;
                    sy_next = sy_reg - two_rx2;
                    br_next = !d_reg[DW-1] && (d_reg != '0);
                    if (d_reg[DW-1] || (d_reg == '0))
                    begin
                        px_next = px_reg + one_p;
                        sx_next = sx_reg + two_ry2;
                    end
                end
                state_next = ST_UPD_SUM;
            end
            ST_UPD_SUM:
            begin
                t_next     = sum_base + sum_sx - sum_sy;
                state_next = ST_UPD_DEC;
            end
            ST_UPD_DEC:
            begin
                d_next     = d_reg + t4;
                state_next = ST_IDLE;
                if (!region_reg)
                begin
                    if (!(sx_reg < sy_reg))
                    begin
                        region_next = 1'b1;
                        state_next  = ST_SW_DX;
                    end
                end
                else if (py_reg[PW-1])
                begin
                    drawing_next = 1'b0;
                end
            end
            ST_SW_DX:
            begin
                state_next = ST_SW_DY;
            end
            ST_SW_DY:
            begin
                t_next     = prod_d;
                state_next = ST_SW_RYDX;
            end
            ST_SW_RYDX:
            begin
                t_next     = prod_d;
                state_next = ST_SW_RXDY;
            end
            ST_SW_RXDY:
            begin
                d_next     = prod_d;
                state_next = ST_SW_ADD;
            end
            ST_SW_ADD:
            begin
                d_next     = d_reg + prod4;
                state_next = ST_SW_SUB;
            end
            ST_SW_SUB:
            begin
                d_next     = d_reg - prod4;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            drawing_reg <= 1'b0;
            region_reg  <= 1'b0;
            br_reg      <= 1'b0;
            quad_reg    <= ellr_pkg::QUAD_PP;
            clip_w_reg  <= ellr_pkg::CLIP_WIDTH_RESET;
            clip_h_reg  <= ellr_pkg::CLIP_HEIGHT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            drawing_reg <= drawing_next;
            region_reg  <= region_next;
            br_reg      <= br_next;
            quad_reg    <= quad_next;
            if (cfg_write_en && (cfg_index == ellr_pkg::CFG_CLIP_WIDTH))
            begin
                clip_w_reg <= cfg_data;
            end
            if (cfg_write_en && (cfg_index == ellr_pkg::CFG_CLIP_HEIGHT))
            begin
                clip_h_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ccol_reg <= ccol_next;
        crow_reg <= crow_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        rx2_reg  <= rx2_next;
        ry2_reg  <= ry2_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        d_reg    <= d_next;
        t_reg    <= t_next;
    end

    ellr_pixel #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_pixel (
        .clk           (clk),
        .rst_n         (rst_n),
        .clip_width    (clip_w_reg),
        .clip_height   (clip_h_reg),
        .center_col    (ccol_reg),
        .center_row    (crow_reg),
        .point_x       (px_reg),
        .point_y       (py_reg),
        .req           (pix_req),
        .free          (pix_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .on_screen     (on_screen),
        .last_of_point (last_of_point),
        .last_of_shape (last_of_shape)
    );

endmodule

/* rtl/core/ellr_mult.sv */
// shared signed multiplier with registered product
// used by the sequencer for squares, the initial decision term and the region change terms; no dependencies
module ellr_mult #(
    parameter int OP_BITS = 25
) (
    input  logic                        clk,
    input  logic signed [OP_BITS-1:0]   a,
    input  logic signed [OP_BITS-1:0]   b,
    output logic signed [2*OP_BITS-1:0] prod
);

    logic signed [2*OP_BITS-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

/* rtl/core/ellr_pixel.sv */
// pixel output stage: mirrors a point about the centre, clips it and holds the item
// depends on ellr_pkg
module ellr_pixel #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ellr_pkg::CLIP_BITS-1:0]      clip_width,
    input  logic [ellr_pkg::CLIP_BITS-1:0]      clip_height,
    input  logic signed [COORD_BITS-1:0]        center_col,
    input  logic signed [COORD_BITS-1:0]        center_row,
    input  logic signed [RADIUS_BITS+1:0]       point_x,
    input  logic signed [RADIUS_BITS+1:0]       point_y,
    input  ellr_pkg::pix_req_t                  req,
    output logic                                free,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_BITS:0]          pixel_x,
    output logic signed [COORD_BITS:0]          pixel_y,
    output logic                                on_screen,
    output logic                                last_of_point,
    output logic                                last_of_shape
);

    localparam int PW  = RADIUS_BITS + 2;
    localparam int CB  = ellr_pkg::CLIP_BITS;
    localparam int BW  = (COORD_BITS > PW) ? COORD_BITS : PW;
    localparam int EW0 = BW + 1;
    localparam int EW  = (EW0 > CB + 1) ? EW0 : CB + 1;

    logic signed [EW-1:0] cx_e, cy_e, px_e, py_e, sum_x, sum_y, clip_w_e, clip_h_e;
    logic                 neg_x, neg_y, on_next;

    logic                     valid_reg;
    logic signed [COORD_BITS:0] pixel_x_reg, pixel_y_reg;
    logic                     on_reg, lastp_reg, lasts_reg;

    assign cx_e     = {{(EW-COORD_BITS){center_col[COORD_BITS-1]}}, center_col};
    assign cy_e     = {{(EW-COORD_BITS){center_row[COORD_BITS-1]}}, center_row};
    assign px_e     = {{(EW-PW){point_x[PW-1]}}, point_x};
    assign py_e     = {{(EW-PW){point_y[PW-1]}}, point_y};
    assign clip_w_e = {{(EW-CB){1'b0}}, clip_width};
    assign clip_h_e = {{(EW-CB){1'b0}}, clip_height};

    assign neg_x = (req.quad == ellr_pkg::QUAD_MP) || (req.quad == ellr_pkg::QUAD_MM);
    assign neg_y = (req.quad == ellr_pkg::QUAD_PM) || (req.quad == ellr_pkg::QUAD_MM);

    assign sum_x = neg_x ? (cx_e - px_e) : (cx_e + px_e);
    assign sum_y = neg_y ? (cy_e - py_e) : (cy_e + py_e);

    // clip on the full-width value, before the port truncation
    assign on_next = !sum_x[EW-1] && (sum_x < clip_w_e)
                  && !sum_y[EW-1] && (sum_y < clip_h_e);

    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            pixel_x_reg <= sum_x[COORD_BITS:0];
            pixel_y_reg <= sum_y[COORD_BITS:0];
            on_reg      <= on_next;
            lastp_reg   <= (req.quad == ellr_pkg::QUAD_MM);
            lasts_reg   <= (req.quad == ellr_pkg::QUAD_MM) && req.final_pt;
        end
    end

    assign out_valid     = valid_reg;
    assign pixel_x       = pixel_x_reg;
    assign pixel_y       = pixel_y_reg;
    assign on_screen     = on_reg;
    assign last_of_point = lastp_reg;
    assign last_of_shape = lasts_reg;

endmodule
